/* hw/rtl/disparity_hue_colorizer_defines.svh */
// Assertion macros used by the checker file.
`ifndef DISPARITY_HUE_COLORIZER_DEFINES_SVH
`define DISPARITY_HUE_COLORIZER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define DHC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, ignored while reset is high.
`define DHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Implication that is also checked around reset.
`define DHC_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`endif

/* hw/rtl/dhc_pkg.sv */
`default_nettype none
package dhc_pkg;

  typedef enum logic [1:0] {
    REG_MAX_DISP   = 2'd0,
    REG_SATURATION = 2'd1,
    REG_VALUE      = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_t;

  // Per-stage advance enables for the channel back end.
  typedef struct packed {
    logic mul;
    logic scale;
    logic out;
  } dhc_adv_t;

  // One full channel: 65536 * 60.
  localparam logic [21:0] DENOM = 22'd3932160;
  // 256 * 60, the numerator term for 1.0 ahead of the value multiply.
  localparam logic signed [16:0] FULL_TERM = 17'sd15360;
  // ceil(2^20 / 60): exact floor division by 60 for inputs up to 15300.
  localparam logic [14:0] RECIP_60 = 15'd17477;
  localparam int RECIP_SHIFT = 20;

endpackage
`default_nettype wire

/* hw/rtl/dhc_chan.sv */
`default_nettype none
module dhc_chan (
  input  logic                    clk,
  input  dhc_pkg::dhc_adv_t       adv,
  input  logic [8:0]              value_q8,
  input  logic signed [16:0]      term,
  output logic [7:0]              level
);
  import dhc_pkg::*;

  logic signed [26:0] prod;
  logic [21:0]        clamped;
  logic [29:0]        scaled;
  logic [13:0]        coarse;
  logic [27:0]        recip_prod;

  assign prod = $signed({1'b0, value_q8}) * term;

  always_ff @(posedge clk) begin
    if (adv.mul) begin
      if (prod[26]) begin
        clamped <= '0;
      end else if (prod[25:0] > 26'(DENOM)) begin
        clamped <= DENOM;
      end else begin
        clamped <= prod[21:0];
      end
    end
  end

  // x * 255, then drop the 2^16 part of the denominator
  assign scaled = {clamped, 8'b0} - {8'b0, clamped};

  always_ff @(posedge clk) begin
    if (adv.scale) begin
      coarse <= scaled[29:16];
    end
  end

  assign recip_prod = 28'(coarse) * 28'(RECIP_60);

  always_ff @(posedge clk) begin
    if (adv.out) begin
      level <= recip_prod[RECIP_SHIFT +: 8];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/disparity_hue_colorizer.sv */
`default_nettype none
// Disparity to colour mapping: one 8-bit disparity pixel in, one blue/green/red
// pixel out, one transaction per clock sustained while out_stall is low, in a
// nine-stage pipeline: one stage forms the hue numerator, four stages resolve
// the hue quotient (max_disp - d) * 240 / max_disp two bits at a time, one stage
// selects the HSV sector terms, and three per-channel stages apply the value
// multiply, clamp and x255 scaling. Disparity 0, or max_disp 0, gives black; a
// disparity above max_disp gives hue 0. Registers (max_disp, saturation_q8,
// value_q8) are written through cfg_wen/cfg_index/cfg_data; the user must write
// them only while no pixel is in flight, and the block does not enforce this.
// A stall on the output holds the pipeline only as far back as it is full.
module disparity_hue_colorizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] disparity,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] blue,
  output logic [7:0] green,
  output logic [7:0] red
);
  import dhc_pkg::*;

  localparam int Stages    = 9;
  localparam int DivStages = 4;
  localparam int SectStage = DivStages + 2;
  localparam logic [5:0] SectorWidth = 6'd60;

  logic [7:0] max_disp;
  logic [8:0] saturation_q8;
  logic [8:0] value_q8;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_disp      <= 8'd255;
      saturation_q8 <= 9'd256;
      value_q8      <= 9'd256;
    end else if (cfg_wen) begin
      case (reg_index_t'(cfg_index))
        REG_MAX_DISP:   max_disp      <= cfg_data[7:0];
        REG_SATURATION: saturation_q8 <= cfg_data;
        REG_VALUE:      value_q8      <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: a stage advances when empty or when the one after it advances
  logic [Stages:1] vld;
  logic [Stages:1] en;

  always_comb begin
    en[Stages] = !vld[Stages] || !out_stall;
    for (int i = Stages - 1; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld[Stages];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= Stages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1 numerator, stages 2..5 hue division
  logic [15:0] rem_q   [0:DivStages];
  logic [7:0]  quot_q  [0:DivStages];
  logic        blank_q [0:DivStages];
  logic [16:0] step_hi [0:DivStages-1];
  logic [16:0] step_lo [0:DivStages-1];
  logic [7:0]  span;

  function automatic logic [16:0] div_step(input logic [15:0] r, input logic [7:0] m,
                                           input int b);
    logic [15:0] ms;
    ms = 16'({8'b0, m} << b);
    if (r >= ms) begin
      return {1'b1, 16'(r - ms)};
    end
    return {1'b0, r};
  endfunction

  assign span = (disparity > max_disp) ? 8'd0 : 8'(max_disp - disparity);

  always_comb begin
    for (int k = 0; k < DivStages; k++) begin
      step_hi[k] = div_step(rem_q[k], max_disp, 7 - 2 * k);
      step_lo[k] = div_step(step_hi[k][15:0], max_disp, 6 - 2 * k);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      // span * 240 = span * 256 - span * 16
      rem_q[0]   <= {span, 8'b0} - {4'b0, span, 4'b0};
      quot_q[0]  <= '0;
      blank_q[0] <= (disparity == 8'd0) || (max_disp == 8'd0);
    end
    for (int k = 0; k < DivStages; k++) begin
      if (en[k+2]) begin
        rem_q[k+1]   <= step_lo[k][15:0];
        quot_q[k+1]  <= {quot_q[k][5:0], step_hi[k][16], step_lo[k][16]};
        blank_q[k+1] <= blank_q[k];
      end
    end
  end

  // stage 6: sector select and saturation terms
  logic [7:0]         hue;
  logic [7:0]         base;
  sector_t            sector;
  logic [5:0]         frac;
  logic [14:0]        rs;
  logic [14:0]        trs;
  logic signed [9:0]  one_minus_s;
  logic signed [16:0] p_term;
  logic signed [16:0] q_term;
  logic signed [16:0] t_term;
  logic signed [16:0] b_sel;
  logic signed [16:0] g_sel;
  logic signed [16:0] r_sel;
  logic signed [16:0] b_term;
  logic signed [16:0] g_term;
  logic signed [16:0] r_term;

  assign hue = quot_q[DivStages];

  always_comb begin
    if (hue >= 8'd240) begin
      sector = SECTOR_4;
      base   = 8'd240;
    end else if (hue >= 8'd180) begin
      sector = SECTOR_3;
      base   = 8'd180;
    end else if (hue >= 8'd120) begin
      sector = SECTOR_2;
      base   = 8'd120;
    end else if (hue >= 8'd60) begin
      sector = SECTOR_1;
      base   = 8'd60;
    end else begin
      sector = SECTOR_0;
      base   = 8'd0;
    end
    frac        = 6'(hue - base);
    rs          = 15'(frac) * 15'(saturation_q8);
    trs         = 15'(SectorWidth - frac) * 15'(saturation_q8);
    one_minus_s = 10'sd256 - $signed({1'b0, saturation_q8});
    p_term      = one_minus_s * 17'sd60;
    q_term      = FULL_TERM - $signed(17'(rs));
    t_term      = FULL_TERM - $signed(17'(trs));
    case (sector)
      SECTOR_0: begin b_sel = p_term;    g_sel = t_term;    r_sel = FULL_TERM; end
      SECTOR_1: begin b_sel = p_term;    g_sel = FULL_TERM; r_sel = q_term;    end
      SECTOR_2: begin b_sel = t_term;    g_sel = FULL_TERM; r_sel = p_term;    end
      SECTOR_3: begin b_sel = FULL_TERM; g_sel = q_term;    r_sel = p_term;    end
      SECTOR_4: begin b_sel = FULL_TERM; g_sel = p_term;    r_sel = t_term;    end
      default:  begin b_sel = q_term;    g_sel = p_term;    r_sel = FULL_TERM; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[SectStage]) begin
      b_term <= blank_q[DivStages] ? 17'sd0 : b_sel;
      g_term <= blank_q[DivStages] ? 17'sd0 : g_sel;
      r_term <= blank_q[DivStages] ? 17'sd0 : r_sel;
    end
  end

  // stages 7..9 per channel
  dhc_adv_t adv;

  assign adv.mul   = en[SectStage+1];
  assign adv.scale = en[SectStage+2];
  assign adv.out   = en[SectStage+3];

  dhc_chan u_chan_blue (
    .clk      (clk),
    .adv      (adv),
    .value_q8 (value_q8),
    .term     (b_term),
    .level    (blue)
  );

  dhc_chan u_chan_green (
    .clk      (clk),
    .adv      (adv),
    .value_q8 (value_q8),
    .term     (g_term),
    .level    (green)
  );

  dhc_chan u_chan_red (
    .clk      (clk),
    .adv      (adv),
    .value_q8 (value_q8),
    .term     (r_term),
    .level    (red)
  );

endmodule
`default_nettype wire

/* hw/rtl/dhc_checker.sv */
`default_nettype none
`include "disparity_hue_colorizer_defines.svh"
module dhc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] blue,
  input logic [7:0] green,
  input logic [7:0] red
);

  // held result stays put
  `DHC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(blue) && $stable(green) && $stable(red))

  // input back-pressure only comes from a full pipe behind a stalled output
  `DHC_ASSERT_IMPLY(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // no transaction leaves straight after reset
  `DHC_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !out_valid && !in_stall)

endmodule

bind disparity_hue_colorizer dhc_checker u_dhc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .blue      (blue),
  .green     (green),
  .red       (red)
);
`default_nettype wire
